### src/pvbr_pkg.sv
// Shared types, constants and helpers for the page valid bitmap block.
`default_nettype none

package pvbr_pkg;

    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;
    // Byte positions reach start + length, at most 4095 + 8191.
    localparam int POS_W     = 14;
    // Highest word count that a byte position can reach.
    localparam int MAX_REACH_WORDS = 192;

    localparam int CMD_W   = 2;
    localparam int START_W = 12;
    localparam int LEN_W   = 13;
    localparam int LIM_W   = 17;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [BIT_W-1:0]     bit_idx_t;
    typedef logic [POS_W-1:0]     pos_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_MARK  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_FIND  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_DONE = 2'd2
    } state_t;

    localparam word_t ALL_ONES = {WORD_BITS{1'b1}};

    // Index of the lowest set bit, zero when none is set.
    function automatic bit_idx_t first_set(input word_t v);
        bit_idx_t idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i])
            begin
                idx = bit_idx_t'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

### src/page_valid_bitmap_runs.sv
// Per-byte valid bitmap of one page: mark, clear and find-first-run commands.
`default_nettype none

//  channel | signals                                        | dir | item
//  --------+------------------------------------------------+-----+----------------------
//  in      | in_valid, in_ready, cmd, range_start,          | in  | one command
//          | range_length                                   |     |
//  out     | out_valid, out_ready, run_offset, run_length,  | out | one result per command
//          | run_found, page_empty, range_error             |     |
//
// Flow: the accept cycle reads the first word, then the walk visits each 64-bit word the
//   range spans (1..64 at the default page; a find stops at the word where its run ends),
//   then the result state. Range errors, no-ops and empty ranges skip the walk. The
//   next accept is the cycle after the result leaves.
// Reset: a valid bit per word makes the whole bitmap read as zero; no sweep.
// Stalls: in_ready is high only while idle; a held result waits on out_ready.
module page_valid_bitmap_runs #(
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic [11:0] range_start,
    input  wire logic [12:0] range_length,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [11:0]      run_offset,
    output logic [12:0]      run_length,
    output logic             run_found,
    output logic             page_empty,
    output logic             range_error
);

    // Words that exist in the page, limited to those a range can reach.
    localparam int MAP_WORDS = (PAGE_BYTES + 63) / 64;
    localparam int WORDS     = (MAP_WORDS < pvbr_pkg::MAX_REACH_WORDS) ?
                               MAP_WORDS : pvbr_pkg::MAX_REACH_WORDS;
    localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW        = $clog2(WORDS + 1);
    localparam logic [pvbr_pkg::LIM_W-1:0] PAGE_LIM = pvbr_pkg::LIM_W'(PAGE_BYTES);

    // Control registers
    pvbr_pkg::state_t  state_reg, state_next;
    pvbr_pkg::cmd_t    cmd_reg, cmd_next;
    logic [11:0]       start_reg, start_next;
    pvbr_pkg::pos_t    end_reg, end_next;
    logic [AW-1:0]     ex_w_reg, ex_w_next;     // word being worked on
    logic [AW-1:0]     ws_reg, ws_next;         // first word of range
    logic [AW-1:0]     we_reg, we_next;         // last word of range
    logic              run_reg, run_next;       // find: inside a run
    pvbr_pkg::pos_t    p_reg, p_next;           // find: absolute run start
    logic [CW-1:0]     cnt_reg, cnt_next;       // nonzero words in the map
    logic [WORDS-1:0]  vld_reg, vld_next;

    // Result registers
    logic [11:0]       off_reg, off_next;
    logic [12:0]       len_reg, len_next;
    logic              found_reg, found_next;
    logic              err_reg, err_next;

    // Bitmap store, registered read
    pvbr_pkg::word_t   mem [WORDS];
    pvbr_pkg::word_t   rd_data_reg;
    logic              rd_vld_reg;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;

    // Datapath
    logic [pvbr_pkg::LIM_W-1:0] end_in;
    logic              err_in;
    pvbr_pkg::pos_t    end_pos_in;
    pvbr_pkg::pos_t    last_pos_in;
    pvbr_pkg::pos_t    last_pos;
    pvbr_pkg::word_t   word;
    pvbr_pkg::word_t   mask;
    pvbr_pkg::word_t   new_word;
    pvbr_pkg::word_t   m_word;
    pvbr_pkg::word_t   z_word;
    pvbr_pkg::bit_idx_t lo_bit, hi_bit, f_bit, g_bit;
    logic              is_first, is_last;
    pvbr_pkg::pos_t    base_pos, p_cur, q_cur;

    assign in_ready    = (state_reg == pvbr_pkg::ST_IDLE);
    assign out_valid   = (state_reg == pvbr_pkg::ST_DONE);
    assign run_offset  = off_reg;
    assign run_length  = len_reg;
    assign run_found   = found_reg;
    assign range_error = err_reg;
    assign page_empty  = (cnt_reg == '0);

    // Range check on the incoming item
    assign end_in      = pvbr_pkg::LIM_W'(range_start) + pvbr_pkg::LIM_W'(range_length);
    assign err_in      = (end_in > PAGE_LIM) && (cmd != pvbr_pkg::CMD_NOP);
    assign end_pos_in  = pvbr_pkg::POS_W'(end_in);
    assign last_pos_in = end_pos_in - pvbr_pkg::pos_t'(1);

    // Word mask covering the range bits inside the current word
    assign word     = rd_vld_reg ? rd_data_reg : '0;
    assign is_first = (ex_w_reg == ws_reg);
    assign is_last  = (ex_w_reg == we_reg);
    assign last_pos = end_reg - pvbr_pkg::pos_t'(1);
    assign lo_bit   = is_first ? start_reg[5:0] : '0;
    assign hi_bit   = is_last ? last_pos[5:0] : pvbr_pkg::bit_idx_t'(63);
    assign mask     = (pvbr_pkg::ALL_ONES << lo_bit) &
                      (pvbr_pkg::ALL_ONES >> (pvbr_pkg::bit_idx_t'(63) - hi_bit));
    assign new_word = (cmd_reg == pvbr_pkg::CMD_MARK) ? (word | mask) : (word & ~mask);

    // Run search: first valid bit, then first invalid bit after it
    assign m_word   = word & mask;
    assign f_bit    = pvbr_pkg::first_set(m_word);
    assign z_word   = ~word & mask & (run_reg ? pvbr_pkg::ALL_ONES :
                                                (pvbr_pkg::ALL_ONES << f_bit));
    assign g_bit    = pvbr_pkg::first_set(z_word);
    assign base_pos = pvbr_pkg::POS_W'({ex_w_reg, pvbr_pkg::bit_idx_t'(0)});
    assign p_cur    = run_reg ? p_reg : (base_pos | pvbr_pkg::POS_W'(f_bit));
    assign q_cur    = (z_word != '0) ? (base_pos | pvbr_pkg::POS_W'(g_bit)) : end_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        start_next = start_reg;
        end_next   = end_reg;
        ex_w_next  = ex_w_reg;
        ws_next    = ws_reg;
        we_next    = we_reg;
        run_next   = run_reg;
        p_next     = p_reg;
        cnt_next   = cnt_reg;
        vld_next   = vld_reg;
        off_next   = off_reg;
        len_next   = len_reg;
        found_next = found_reg;
        err_next   = err_reg;
        rd_en      = 1'b0;
        rd_addr    = ex_w_reg + AW'(1);
        wr_en      = 1'b0;

        unique case (state_reg)
            pvbr_pkg::ST_IDLE:
            begin
                rd_addr = AW'(range_start >> 6);
                if (in_valid)
                begin
                    cmd_next   = pvbr_pkg::cmd_t'(cmd);
                    start_next = range_start;
                    end_next   = end_pos_in;
                    ws_next    = AW'(range_start >> 6);
                    we_next    = AW'(last_pos_in >> 6);
                    ex_w_next  = AW'(range_start >> 6);
                    run_next   = 1'b0;
                    off_next   = '0;
                    len_next   = '0;
                    found_next = 1'b0;
                    err_next   = err_in;
                    if (err_in || (cmd == pvbr_pkg::CMD_NOP) || (range_length == '0))
                    begin
                        state_next = pvbr_pkg::ST_DONE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        state_next = pvbr_pkg::ST_SCAN;
                    end
                end
            end

            pvbr_pkg::ST_SCAN:
            begin
                rd_en     = !is_last;
                ex_w_next = ex_w_reg + AW'(1);
                if (cmd_reg == pvbr_pkg::CMD_FIND)
                begin
                    if (run_reg || (m_word != '0))
                    begin
                        if ((z_word != '0) || is_last)
                        begin
                            off_next   = 12'(p_cur - pvbr_pkg::POS_W'(start_reg));
                            len_next   = 13'(q_cur - p_cur);
                            found_next = 1'b1;
                            state_next = pvbr_pkg::ST_DONE;
                        end
                        else
                        begin
                            run_next = 1'b1;
                            p_next   = p_cur;
                        end
                    end
                    else if (is_last)
                    begin
                        state_next = pvbr_pkg::ST_DONE;
                    end
                end
                else
                begin
                    // mark or clear: read-modify-write, track nonzero words
                    wr_en              = 1'b1;
                    vld_next[ex_w_reg] = 1'b1;
                    if ((word == '0) && (new_word != '0))
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else if ((word != '0) && (new_word == '0))
                    begin
                        cnt_next = cnt_reg - CW'(1);
                    end
                    if (is_last)
                    begin
                        state_next = pvbr_pkg::ST_DONE;
                    end
                end
            end

            pvbr_pkg::ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = pvbr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pvbr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pvbr_pkg::ST_IDLE;
            run_reg    <= 1'b0;
            cnt_reg    <= '0;
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            run_reg   <= run_next;
            cnt_reg   <= cnt_next;
            vld_reg   <= vld_next;
            if (rd_en)
            begin
                rd_vld_reg <= vld_next[rd_addr];
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        start_reg <= start_next;
        end_reg   <= end_next;
        ex_w_reg  <= ex_w_next;
        ws_reg    <= ws_next;
        we_reg    <= we_next;
        p_reg     <= p_next;
        off_reg   <= off_next;
        len_reg   <= len_next;
        found_reg <= found_next;
        err_reg   <= err_next;
    end

    // Bitmap memory; write and next read never share an address
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[ex_w_reg] <= new_word;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### tb/page_valid_bitmap_runs_tb.sv
// Self-checking testbench for the page valid bitmap: mark, clear and find-run commands.
`default_nettype none

module page_valid_bitmap_runs_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGE_BYTES     = 4096;
    // The longest quiet stretch of a correct run is a full-page walk plus
    // a receiver stall and a sender gap.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 150;

    // One result item as the block reports it.
    typedef struct packed {
        logic [pvbr_pkg::START_W-1:0] run_offset;
        logic [pvbr_pkg::LEN_W-1:0]   run_length;
        logic                         run_found;
        logic                         page_empty;
        logic                         range_error;
    } run_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic [pvbr_pkg::CMD_W-1:0]   cmd;
    logic [pvbr_pkg::START_W-1:0] range_start;
    logic [pvbr_pkg::LEN_W-1:0]   range_length;
    logic                         out_valid;
    logic                         out_ready;
    logic [pvbr_pkg::START_W-1:0] run_offset;
    logic [pvbr_pkg::LEN_W-1:0]   run_length;
    logic                         run_found;
    logic                         page_empty;
    logic                         range_error;

    // Shadow of the page bitmap, one bit per byte.
    logic [PAGE_BYTES-1:0] byte_valid;
    // Results owed by the block, oldest first.
    run_result_t           pending_results[$];
    run_result_t           want_result;

    int fail_count  = 0;
    int quiet_cycles = 0;
    int rx_stall    = 0;
    bit rx_took     = 1'b0;
    // When set, neither side idles: back-to-back traffic.
    bit no_idle     = 1'b0;

    page_valid_bitmap_runs #(
        .PAGE_BYTES(PAGE_BYTES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .range_start (range_start),
        .range_length(range_length),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .run_offset  (run_offset),
        .run_length  (run_length),
        .run_found   (run_found),
        .page_empty  (page_empty),
        .range_error (range_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Applies one command to the shadow bitmap and returns what the block
    // must report for it. A range past the page end leaves the map alone;
    // a find looks only inside [start, start+len), so runs get cut at both
    // ends of the range. Emptiness is reported after every command.
    function automatic run_result_t predict_command(
        input pvbr_pkg::cmd_t op,
        input logic [pvbr_pkg::START_W-1:0] start,
        input logic [pvbr_pkg::LEN_W-1:0] len);
        int unsigned lo;
        int unsigned hi;
        int unsigned p;
        int unsigned q;
        run_result_t r;
        r  = '0;
        lo = start;
        hi = lo + len;
        if (op != pvbr_pkg::CMD_NOP && hi > PAGE_BYTES)
        begin
            r.range_error = 1'b1;
        end
        else if (op == pvbr_pkg::CMD_MARK || op == pvbr_pkg::CMD_CLEAR)
        begin
            for (p = lo; p < hi; p++)
            begin
                byte_valid[p] = (op == pvbr_pkg::CMD_MARK);
            end
        end
        else if (op == pvbr_pkg::CMD_FIND)
        begin
            p = lo;
            while (p < hi && !byte_valid[p])
            begin
                p++;
            end
            if (p < hi)
            begin
                q = p;
                while (q < hi && byte_valid[q])
                begin
                    q++;
                end
                r.run_offset = pvbr_pkg::START_W'(p - lo);
                r.run_length = pvbr_pkg::LEN_W'(q - p);
                r.run_found  = 1'b1;
            end
        end
        r.page_empty = (byte_valid == '0);
        return r;
    endfunction

    // Range length: mostly short, sometimes up to the page end, now and
    // then any 13-bit value so that overruns and the top length bit occur.
    function automatic int unsigned pick_span(input int unsigned start);
        int unsigned room;
        int unsigned span;
        int sel;
        room = PAGE_BYTES - start;
        sel  = $urandom_range(0, 99);
        if (sel < 55)
        begin
            span = $urandom_range(0, 100);
        end
        else if (sel < 75)
        begin
            span = $urandom_range(0, 700);
        end
        else if (sel < 85)
        begin
            return room;
        end
        else if (sel < 93)
        begin
            span = $urandom_range(0, room);
        end
        else
        begin
            return $urandom_range(0, 8191);
        end
        return (span < room) ? span : room;
    endfunction

    // Sends one command item. Entered and left just after a falling edge;
    // valid stays high with a fixed payload until the item is taken.
    task automatic send_command(input pvbr_pkg::cmd_t op, input int unsigned start,
                                input int unsigned len, output run_result_t predicted);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd          = op;
        range_start  = start[pvbr_pkg::START_W-1:0];
        range_length = len[pvbr_pkg::LEN_W-1:0];
        in_valid     = 1'b1;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predicted = predict_command(op, range_start, range_length);
        pending_results.insert(pending_results.size(), predicted);
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [pvbr_pkg::LEN_W-1:0] want,
                               input logic [pvbr_pkg::LEN_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            rx_took = 1'b1;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result expected none, got offset %0d length %0d found %0d",
                         $time, run_offset, run_length, run_found);
                fail_count++;
            end
            else
            begin
                want_result = pending_results.pop_front();
                check_field("run_offset", pvbr_pkg::LEN_W'(want_result.run_offset),
                            pvbr_pkg::LEN_W'(run_offset));
                check_field("run_length", want_result.run_length, run_length);
                check_field("run_found", pvbr_pkg::LEN_W'(want_result.run_found),
                            pvbr_pkg::LEN_W'(run_found));
                check_field("page_empty", pvbr_pkg::LEN_W'(want_result.page_empty),
                            pvbr_pkg::LEN_W'(page_empty));
                check_field("range_error", pvbr_pkg::LEN_W'(want_result.range_error),
                            pvbr_pkg::LEN_W'(range_error));
            end
        end
    end

    // Receiver: after each taken result, may hold ready low before taking the next one.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_took)
            begin
                rx_stall = no_idle ? 0 : $urandom_range(0, 3);
                rx_took  = 1'b0;
            end
            out_ready = (rx_stall == 0);
            if (rx_stall > 0)
            begin
                rx_stall--;
            end
        end
    end

    // Watchdog: ends the run when no item moves on either side for too long.
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("%0t: watchdog, no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Fresh page: nothing to find, page empty; a no-op ignores an overrun.
    task automatic test_reset_state;
        run_result_t seen;
        send_command(pvbr_pkg::CMD_FIND, 0, PAGE_BYTES, seen);
        send_command(pvbr_pkg::CMD_NOP, 4095, 8191, seen);
    endtask

    // Ranges past the page end are flagged and change nothing.
    task automatic test_range_errors;
        run_result_t seen;
        send_command(pvbr_pkg::CMD_MARK, 4095, 2, seen);
        send_command(pvbr_pkg::CMD_CLEAR, 1, PAGE_BYTES, seen);
        send_command(pvbr_pkg::CMD_FIND, 0, PAGE_BYTES + 1, seen);
        send_command(pvbr_pkg::CMD_FIND, 4095, 8191, seen);
        send_command(pvbr_pkg::CMD_MARK, 0, 8191, seen);
    endtask

    // Page ends, word boundaries, runs cut at range start and end,
    // zero-length ranges, full-page mark/find/clear.
    task automatic test_edges_and_cuts;
        run_result_t seen;
        send_command(pvbr_pkg::CMD_MARK, 0, 1, seen);
        send_command(pvbr_pkg::CMD_MARK, 4095, 1, seen);
        send_command(pvbr_pkg::CMD_FIND, 0, PAGE_BYTES, seen);
        send_command(pvbr_pkg::CMD_FIND, 1, 4095, seen);
        send_command(pvbr_pkg::CMD_MARK, 60, 10, seen);
        send_command(pvbr_pkg::CMD_FIND, 65, 100, seen);
        send_command(pvbr_pkg::CMD_FIND, 60, 3, seen);
        send_command(pvbr_pkg::CMD_MARK, 200, 0, seen);
        send_command(pvbr_pkg::CMD_FIND, 10, 0, seen);
        send_command(pvbr_pkg::CMD_CLEAR, 0, 0, seen);
        send_command(pvbr_pkg::CMD_MARK, 0, PAGE_BYTES, seen);
        send_command(pvbr_pkg::CMD_FIND, 0, PAGE_BYTES, seen);
        send_command(pvbr_pkg::CMD_FIND, 4095, 1, seen);
        send_command(pvbr_pkg::CMD_CLEAR, 0, PAGE_BYTES, seen);
        send_command(pvbr_pkg::CMD_CLEAR, 0, PAGE_BYTES, seen);
    endtask

    // Dirty the map, then walk a window run by run the way a caller would,
    // restarting each find right after the run just reported.
    task automatic test_run_walk(input int rounds);
        run_result_t seen;
        int unsigned s;
        int unsigned lo;
        int unsigned hi;
        repeat (rounds)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                send_command(pvbr_pkg::CMD_CLEAR, 0, PAGE_BYTES, seen);
            end
            repeat ($urandom_range(1, 5))
            begin
                s = $urandom_range(0, PAGE_BYTES - 1);
                send_command(pvbr_pkg::CMD_MARK, s, pick_span(s), seen);
            end
            s = $urandom_range(0, PAGE_BYTES - 1);
            send_command(pvbr_pkg::CMD_CLEAR, s, pick_span(s), seen);
            if ($urandom_range(0, 4) == 0)
            begin
                lo = 0;
                hi = PAGE_BYTES;
            end
            else
            begin
                lo = $urandom_range(0, PAGE_BYTES - 1);
                hi = $urandom_range(lo, PAGE_BYTES);
            end
            s = lo;
            do
            begin
                send_command(pvbr_pkg::CMD_FIND, s, hi - s, seen);
                if (seen.run_found)
                begin
                    s = s + seen.run_offset + seen.run_length;
                end
            end
            while (seen.run_found && s < hi);
        end
    endtask

    // Fill part of the page, then clear it in random chunks until empty.
    task automatic test_drain_to_empty(input int passes);
        run_result_t seen;
        int unsigned s;
        int unsigned chunk;
        repeat (passes)
        begin
            repeat (6)
            begin
                s = $urandom_range(0, PAGE_BYTES - 1);
                send_command(pvbr_pkg::CMD_MARK, s, $urandom_range(1, PAGE_BYTES - s), seen);
            end
            s = 0;
            while (s < PAGE_BYTES)
            begin
                chunk = $urandom_range(1, 400);
                if (chunk > PAGE_BYTES - s)
                begin
                    chunk = PAGE_BYTES - s;
                end
                send_command(pvbr_pkg::CMD_CLEAR, s, chunk, seen);
                s += chunk;
            end
        end
    endtask

    task automatic send_random_command;
        run_result_t seen;
        int unsigned s;
        int sel;
        pvbr_pkg::cmd_t op;
        sel = $urandom_range(0, 99);
        if (sel < 35)
        begin
            op = pvbr_pkg::CMD_MARK;
        end
        else if (sel < 60)
        begin
            op = pvbr_pkg::CMD_CLEAR;
        end
        else if (sel < 96)
        begin
            op = pvbr_pkg::CMD_FIND;
        end
        else
        begin
            op = pvbr_pkg::CMD_NOP;
        end
        s = $urandom_range(0, PAGE_BYTES - 1);
        send_command(op, s, pick_span(s), seen);
    endtask

    task automatic test_random_mix(input int count);
        repeat (count)
        begin
            send_random_command();
        end
    endtask

    // Same mix with both sides always ready: items back to back.
    task automatic test_back_to_back(input int count);
        no_idle = 1'b1;
        repeat (count)
        begin
            send_random_command();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        cmd          = pvbr_pkg::CMD_NOP;
        range_start  = '0;
        range_length = '0;
        byte_valid   = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_range_errors();
        test_edges_and_cuts();
        test_run_walk(60);
        test_random_mix(450);
        test_back_to_back(120);
        test_drain_to_empty(3);
        test_random_mix(450);

        in_valid = 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        // Let any stray result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
src/pvbr_pkg.sv
src/page_valid_bitmap_runs.sv
tb/page_valid_bitmap_runs_tb.sv
